>>> design/u16d_pkg.sv
`timescale 1ns / 1ps
package u16d_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned CpW    = 21;
   localparam int unsigned CountW = 2;

   localparam logic [ByteW-1:0] SurrMask    = 8'hFC;
   localparam logic [ByteW-1:0] HighSurrTag = 8'hD8;
   localparam logic [ByteW-1:0] LowSurrTag  = 8'hDC;
   localparam logic [CpW-1:0]   SuppBase    = 21'h010000;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic [CountW-1:0] COUNT_NONE  = 2'd0;
   localparam logic [CountW-1:0] COUNT_ONE   = 2'd1;
   localparam logic [CountW-1:0] COUNT_TWO   = 2'd2;
   localparam logic [CountW-1:0] COUNT_THREE = 2'd3;

   typedef struct packed {
      logic             valid;
      logic [ByteW-1:0] data_byte;
   } stage_type;

endpackage

>>> design/u16d_if.sv
`timescale 1ns / 1ps
interface u16d_req_if
   import u16d_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface u16d_rsp_if
   import u16d_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              status;
   logic [CpW-1:0]    code_point;
   logic [CountW-1:0] significant_bytes;

   modport source (output valid, output status, output code_point,
                   output significant_bytes, input ready);
   modport sink   (input valid, input status, input code_point,
                   input significant_bytes, output ready);
endinterface

>>> design/utf16be_byte_decoder_top.sv
// A byte is registered on transfer; its result, if any, goes to the result register.
// Throughput: one byte per cycle unless the output stalls; each register holds one entry.
// Ready on the input path follows the result register's ready combinationally.
// Reset (synchronous, active high) clears the decode phase and both valid flags;
// held bytes and result payload are not reset.
`timescale 1ns / 1ps
module utf16be_byte_decoder_top
   import u16d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   u16d_req_if.sink   req_chan,
   u16d_rsp_if.source rsp_chan
);

   stage_type stage;
   logic      stage_go;

   u16d_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .stage_go (stage_go),
      .stage    (stage)
   );

   u16d_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .stage_go (stage_go),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> design/u16d_in_reg.sv
`timescale 1ns / 1ps
module u16d_in_reg
   import u16d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   u16d_req_if.sink   req_chan,
   input  logic       stage_go,
   output stage_type  stage
);

   logic             valid_ff, valid_in;
   logic [ByteW-1:0] byte_ff, byte_in;
   logic             take;

   assign req_chan.ready = !valid_ff || stage_go;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff && !stage_go;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_chan.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid     = valid_ff;
   assign stage.data_byte = byte_ff;

endmodule

>>> design/u16d_decode.sv
`timescale 1ns / 1ps
module u16d_decode
   import u16d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  stage_type  stage,
   output logic       stage_go,
   u16d_rsp_if.source rsp_chan
);

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;
   localparam logic [1:0] PH_FOURTH = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [ByteW-1:0]  held_ff [3];
   logic [ByteW-1:0]  held_in [3];
   logic              out_valid_ff, out_valid_in;
   logic              status_ff, status_in;
   logic [CpW-1:0]    cp_ff, cp_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              out_free;
   logic [CpW-1:0]    bmp_cp;
   logic [CpW-1:0]    supp_cp;
   logic [CountW-1:0] bmp_count;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign stage_go = stage.valid && out_free;

   assign bmp_cp  = {5'd0, held_ff[0], stage.data_byte};
   assign supp_cp = SuppBase + {1'b0, held_ff[0][1:0], held_ff[1],
                                held_ff[2][1:0], stage.data_byte};

   always_comb begin
      if (held_ff[0] != '0) begin
         bmp_count = COUNT_TWO;
      end else if (stage.data_byte != '0) begin
         bmp_count = COUNT_ONE;
      end else begin
         bmp_count = COUNT_NONE;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      held_in      = held_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      cp_in        = cp_ff;
      count_in     = count_ff;
      if (stage_go) begin
         case (phase_ff)
            PH_FIRST: begin
               held_in[0] = stage.data_byte;
               phase_in   = PH_SECOND;
            end
            PH_SECOND: begin
               held_in[1] = stage.data_byte;
               if ((held_ff[0] & SurrMask) == HighSurrTag) begin
                  phase_in = PH_THIRD;
               end else begin
                  phase_in     = PH_FIRST;
                  out_valid_in = 1'b1;
                  status_in    = STATUS_OK;
                  cp_in        = bmp_cp;
                  count_in     = bmp_count;
               end
            end
            PH_THIRD: begin
               held_in[2] = stage.data_byte;
               phase_in   = PH_FOURTH;
            end
            default: begin
               phase_in     = PH_FIRST;
               out_valid_in = 1'b1;
               if ((held_ff[2] & SurrMask) == LowSurrTag) begin
                  status_in = STATUS_OK;
                  cp_in     = supp_cp;
                  count_in  = COUNT_THREE;
               end else begin
                  status_in = STATUS_ERR;
                  cp_in     = '0;
                  count_in  = COUNT_NONE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      held_ff   <= held_in;
      status_ff <= status_in;
      cp_ff     <= cp_in;
      count_ff  <= count_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.status            = status_ff;
   assign rsp_chan.code_point        = cp_ff;
   assign rsp_chan.significant_bytes = count_ff;

endmodule
